// ===== rtl/gbn_pkg.sv =====
package gbn_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MSG_SLOTS_DEF  = 1024;
  localparam int unsigned WINDOW_MAX_DEF = 64;

  // Field widths
  localparam int unsigned OP_W      = 2;
  localparam int unsigned LO_W      = 64;
  localparam int unsigned MID_W     = 64;
  localparam int unsigned HI_W      = 32;
  localparam int unsigned PKT_W     = 16;
  localparam int unsigned PSUM_W    = 32;
  localparam int unsigned OSEQ_W    = 10;
  localparam int unsigned OSUM_W    = 13;
  localparam int unsigned CAUSE_W   = 2;
  localparam int unsigned WIN_W     = 7;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 16;

  localparam int unsigned PAYLOAD_BYTES = 20;

  // One stored message: {checksum, hi, mid, lo}
  localparam int unsigned STORE_W = OSUM_W + HI_W + MID_W + LO_W;

  // Register reset values
  localparam logic [WIN_W-1:0] WINDOW_RST  = 7'd8;
  localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd12;

  // Operation codes
  localparam logic [OP_W-1:0] OP_SEND = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK = 2'd2;

  // Transmit cause codes
  localparam logic [CAUSE_W-1:0] CAUSE_FRESH = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_SLIDE = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_RETX  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 1'd1;

endpackage

// ===== rtl/gbn_intf.sv =====
// Input channel: send, ack and tick commands
interface gbn_in_if;
  logic                                valid;
  logic                                ready;
  logic [gbn_pkg::OP_W-1:0]            op;
  logic [gbn_pkg::LO_W-1:0]            payload_lo;
  logic [gbn_pkg::MID_W-1:0]           payload_mid;
  logic [gbn_pkg::HI_W-1:0]            payload_hi;
  logic [gbn_pkg::PKT_W-1:0]           pkt_seq;
  logic [gbn_pkg::PKT_W-1:0]           pkt_ack;
  logic signed [gbn_pkg::PSUM_W-1:0]   pkt_sum;

  modport source (output valid, op, payload_lo, payload_mid, payload_hi,
                  pkt_seq, pkt_ack, pkt_sum, input ready);
  modport sink   (input valid, op, payload_lo, payload_mid, payload_hi,
                  pkt_seq, pkt_ack, pkt_sum, output ready);
endinterface

// Output channel: transmitted data packets
interface gbn_out_if;
  logic                                valid;
  logic                                ready;
  logic [gbn_pkg::OSEQ_W-1:0]          out_seq;
  logic signed [gbn_pkg::OSUM_W-1:0]   out_sum;
  logic [gbn_pkg::LO_W-1:0]            out_lo;
  logic [gbn_pkg::MID_W-1:0]           out_mid;
  logic [gbn_pkg::HI_W-1:0]            out_hi;
  logic [gbn_pkg::CAUSE_W-1:0]         cause;
  logic                                last;

  modport source (output valid, out_seq, out_sum, out_lo, out_mid, out_hi,
                  cause, last, input ready);
  modport sink   (input valid, out_seq, out_sum, out_lo, out_mid, out_hi,
                  cause, last, output ready);
endinterface

// Configuration write channel
interface gbn_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [gbn_pkg::CFG_IDX_W-1:0]       index;
  logic [gbn_pkg::CFG_DAT_W-1:0]       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/gbn_ram.sv =====
module gbn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port; read data holds without re
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/gbn_bytesum.sv =====
module gbn_bytesum (
  input  logic [gbn_pkg::LO_W-1:0]          lo_i,
  input  logic [gbn_pkg::MID_W-1:0]         mid_i,
  input  logic [gbn_pkg::HI_W-1:0]          hi_i,
  output logic signed [gbn_pkg::OSUM_W-1:0] sum_o
);

  localparam int unsigned SW = gbn_pkg::OSUM_W;

  logic [7:0]           bytes [gbn_pkg::PAYLOAD_BYTES];
  logic signed [SW-1:0] lvl1  [10];
  logic signed [SW-1:0] lvl2  [5];

  // Unpack the 20 payload bytes
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bytes[i]     = lo_i[8*i +: 8];
      bytes[8 + i] = mid_i[8*i +: 8];
    end
    for (int i = 0; i < 4; i++) begin
      bytes[16 + i] = hi_i[8*i +: 8];
    end
  end

  // Adder tree over sign-extended bytes
  always_comb begin
    for (int i = 0; i < 10; i++) begin
      lvl1[i] = $signed({{(SW-8){bytes[2*i][7]}}, bytes[2*i]})
              + $signed({{(SW-8){bytes[2*i+1][7]}}, bytes[2*i+1]});
    end
    for (int i = 0; i < 5; i++) begin
      lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    end
  end

  assign sum_o = (lvl2[0] + lvl2[1]) + (lvl2[2] + lvl2[3]) + lvl2[4];

endmodule

// ===== rtl/go_back_n_sender.sv =====
// Go-Back-N sender. Every input transaction is accepted in IDLE, where its
// payload bytes are added up, and then updates window, timer and message
// store in EXEC. A send that finds the store not full writes the message RAM
// in EXEC and, if the packet lies in the window, reads it back in BURST. An
// ACK that slides the window or a tick that expires the timer then streams
// its packets out of the single-port-read message RAM at one per cycle while
// the output is taken. The RAM's read register is the output register: a new
// input is accepted while the final packet of the previous one still waits.
// The message store needs no clearing pass after reset; configuration writes
// are always taken.
module go_back_n_sender #(
  parameter int unsigned MSG_SLOTS  = gbn_pkg::MSG_SLOTS_DEF,
  parameter int unsigned WINDOW_MAX = gbn_pkg::WINDOW_MAX_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gbn_in_if.sink     in_i,
  gbn_out_if.source  out_o,
  gbn_cfg_if.sink    cfg_i
);

  localparam int unsigned SEQ_W = $clog2(MSG_SLOTS);
  localparam int unsigned CNT_W = SEQ_W + 1;
  localparam int unsigned WIN_W = gbn_pkg::WIN_W;
  localparam int unsigned EW    = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int unsigned SW    = gbn_pkg::OSUM_W;
  localparam int unsigned TW    = gbn_pkg::TMO_W;
  localparam int unsigned PW    = gbn_pkg::PKT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_BURST = 2'd2;

  // Control state
  logic [1:0]                 state_q, state_d;
  logic [WIN_W-1:0]           win_size_q, win_size_d;
  logic [TW-1:0]              timeout_q, timeout_d;
  logic [CNT_W-1:0]           base_q, base_d;
  logic [CNT_W-1:0]           last_sent_q, last_sent_d;
  logic [CNT_W-1:0]           next_seq_q, next_seq_d;
  logic [TW-1:0]              timer_left_q, timer_left_d;
  logic                       timer_on_q, timer_on_d;
  logic [CNT_W-1:0]           cur_q, cur_d;
  logic [CNT_W-1:0]           end_q, end_d;
  logic [gbn_pkg::CAUSE_W-1:0] bcause_q, bcause_d;
  logic                       out_valid_q, out_valid_d;

  // Latched input transaction
  logic [gbn_pkg::OP_W-1:0]   op_q;
  logic [gbn_pkg::LO_W-1:0]   lo_q;
  logic [gbn_pkg::MID_W-1:0]  mid_q;
  logic [gbn_pkg::HI_W-1:0]   hi_q;
  logic [PW-1:0]              pseq_q;
  logic [PW-1:0]              pack_q;
  logic [gbn_pkg::PSUM_W-1:0] psum_q;
  logic signed [SW-1:0]       bsum_q;
  logic signed [SW-1:0]       bsum;

  // Output side registers
  logic [gbn_pkg::OSEQ_W-1:0]  oseq_q;
  logic [gbn_pkg::CAUSE_W-1:0] ocause_q;
  logic                        olast_q;

  // RAM ports
  logic                        ram_we;
  logic                        ram_re;
  logic [gbn_pkg::STORE_W-1:0] ram_wdata;
  logic [gbn_pkg::STORE_W-1:0] ram_rdata;

  // Execute-stage arithmetic
  logic [WIN_W-1:0]           eff_win;
  logic [TW-1:0]              timer_load;
  logic                       store_full;
  logic                       send_in_win;
  logic [SW-1:0]              send_sum;
  logic [gbn_pkg::PSUM_W-1:0] ack_calc;
  logic                       ack_ok;
  logic [CNT_W-1:0]           base_new;
  logic [EW-1:0]              slide_lim;
  logic [CNT_W-1:0]           slide_end;
  logic [CNT_W-1:0]           slide_start;
  logic [EW-1:0]              retx_lim;
  logic [CNT_W-1:0]           retx_end;
  logic                       in_fire;
  logic                       out_fire;
  logic                       burst_last;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;

  // Byte sum of the incoming payload, registered at accept
  gbn_bytesum u_bytesum (
    .lo_i  (in_i.payload_lo),
    .mid_i (in_i.payload_mid),
    .hi_i  (in_i.payload_hi),
    .sum_o (bsum)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= in_i.op;
      lo_q   <= in_i.payload_lo;
      mid_q  <= in_i.payload_mid;
      hi_q   <= in_i.payload_hi;
      pseq_q <= in_i.pkt_seq;
      pack_q <= in_i.pkt_ack;
      psum_q <= in_i.pkt_sum;
      bsum_q <= bsum;
    end
  end

  // Window and timer helpers
  always_comb begin
    if (win_size_q == '0) begin
      eff_win = WIN_W'(1);
    end else if (win_size_q > WIN_W'(WINDOW_MAX)) begin
      eff_win = WIN_W'(WINDOW_MAX);
    end else begin
      eff_win = win_size_q;
    end
  end

  assign timer_load = (timeout_q == '0) ? TW'(1) : timeout_q;

  // Send: store-full check, window check, stored checksum
  assign store_full  = (next_seq_q >= CNT_W'(MSG_SLOTS));
  assign send_in_win = EW'(next_seq_q) < (EW'(base_q) + EW'(eff_win));
  assign send_sum    = SW'(next_seq_q) + bsum_q;

  // ACK: checksum and range checks, new base and slide range
  assign ack_calc = gbn_pkg::PSUM_W'(pseq_q) + gbn_pkg::PSUM_W'(pack_q)
                  + {{(gbn_pkg::PSUM_W-SW){bsum_q[SW-1]}}, bsum_q};
  assign ack_ok   = (ack_calc == psum_q) && !(pack_q < PW'(base_q))
                  && !(pack_q > PW'(last_sent_q));
  assign base_new    = CNT_W'({1'b0, pack_q} + (PW+1)'(1));
  assign slide_lim   = EW'(base_new) + EW'(eff_win);
  assign slide_end   = (EW'(next_seq_q) < slide_lim) ? next_seq_q : CNT_W'(slide_lim);
  assign slide_start = last_sent_q + CNT_W'(1);

  // Timeout: resend base..last_sent, at most WINDOW_MAX packets
  assign retx_lim = EW'(base_q) + EW'(WINDOW_MAX);
  assign retx_end = (EW'(slide_start) < retx_lim) ? slide_start : CNT_W'(retx_lim);

  // Burst read issue: the RAM read register is the output register
  assign ram_re     = (state_q == ST_BURST) && (!out_valid_q || out_o.ready);
  assign burst_last = ((cur_q + CNT_W'(1)) == end_q);

  assign ram_we    = (state_q == ST_EXEC) && (op_q == gbn_pkg::OP_SEND) && !store_full;
  assign ram_wdata = {send_sum, hi_q, mid_q, lo_q};

  // Sequencer
  always_comb begin
    state_d      = state_q;
    win_size_d   = win_size_q;
    timeout_d    = timeout_q;
    base_d       = base_q;
    last_sent_d  = last_sent_q;
    next_seq_d   = next_seq_q;
    timer_left_d = timer_left_q;
    timer_on_d   = timer_on_q;
    cur_d        = cur_q;
    end_d        = end_q;
    bcause_d     = bcause_q;
    out_valid_d  = out_valid_q;

    // Configuration writes
    if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        gbn_pkg::CFG_WINDOW_SIZE:   win_size_d = cfg_i.data[WIN_W-1:0];
        gbn_pkg::CFG_TIMEOUT_TICKS: timeout_d  = cfg_i.data[TW-1:0];
        default: ;
      endcase
    end

    // Output register occupancy
    if (ram_re) begin
      out_valid_d = 1'b1;
    end else if (out_fire) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_IDLE;
        unique case (op_q)
          gbn_pkg::OP_SEND: begin
            if (!store_full) begin
              next_seq_d = next_seq_q + CNT_W'(1);
              if (send_in_win) begin
                last_sent_d = next_seq_q;
                cur_d       = next_seq_q;
                end_d       = next_seq_q + CNT_W'(1);
                bcause_d    = gbn_pkg::CAUSE_FRESH;
                state_d     = ST_BURST;
                if (base_q == next_seq_q) begin
                  timer_left_d = timer_load;
                  timer_on_d   = 1'b1;
                end
              end
            end
          end
          gbn_pkg::OP_ACK: begin
            if (ack_ok) begin
              base_d = base_new;
              if (slide_start < slide_end) begin
                cur_d       = slide_start;
                end_d       = slide_end;
                last_sent_d = slide_end - CNT_W'(1);
                bcause_d    = gbn_pkg::CAUSE_SLIDE;
                state_d     = ST_BURST;
              end
              if (base_new == next_seq_q) begin
                timer_on_d = 1'b0;
              end else begin
                timer_left_d = timer_load;
                timer_on_d   = 1'b1;
              end
            end
          end
          gbn_pkg::OP_TICK: begin
            if (timer_on_q) begin
              if (timer_left_q > TW'(1)) begin
                timer_left_d = timer_left_q - TW'(1);
              end else begin
                timer_left_d = timer_load;
                if (base_q < retx_end) begin
                  cur_d    = base_q;
                  end_d    = retx_end;
                  bcause_d = gbn_pkg::CAUSE_RETX;
                  state_d  = ST_BURST;
                end
              end
            end
          end
          default: ;
        endcase
      end
      ST_BURST: begin
        if (ram_re) begin
          cur_d = cur_q + CNT_W'(1);
          if (burst_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      win_size_q   <= gbn_pkg::WINDOW_RST;
      timeout_q    <= gbn_pkg::TIMEOUT_RST;
      base_q       <= CNT_W'(1);
      last_sent_q  <= '0;
      next_seq_q   <= CNT_W'(1);
      timer_left_q <= '0;
      timer_on_q   <= 1'b0;
      cur_q        <= '0;
      end_q        <= '0;
      bcause_q     <= gbn_pkg::CAUSE_FRESH;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      win_size_q   <= win_size_d;
      timeout_q    <= timeout_d;
      base_q       <= base_d;
      last_sent_q  <= last_sent_d;
      next_seq_q   <= next_seq_d;
      timer_left_q <= timer_left_d;
      timer_on_q   <= timer_on_d;
      cur_q        <= cur_d;
      end_q        <= end_d;
      bcause_q     <= bcause_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Side fields travel with the RAM read
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      oseq_q   <= gbn_pkg::OSEQ_W'(cur_q);
      ocause_q <= bcause_q;
      olast_q  <= burst_last;
    end
  end

  // Message store
  gbn_ram #(
    .WIDTH (gbn_pkg::STORE_W),
    .DEPTH (MSG_SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (next_seq_q[SEQ_W-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cur_q[SEQ_W-1:0]),
    .rdata_o (ram_rdata)
  );

  // Output channel
  assign out_o.valid   = out_valid_q;
  assign out_o.out_seq = oseq_q;
  assign out_o.out_lo  = ram_rdata[gbn_pkg::LO_W-1:0];
  assign out_o.out_mid = ram_rdata[gbn_pkg::LO_W +: gbn_pkg::MID_W];
  assign out_o.out_hi  = ram_rdata[gbn_pkg::LO_W + gbn_pkg::MID_W +: gbn_pkg::HI_W];
  assign out_o.out_sum = $signed(ram_rdata[gbn_pkg::STORE_W-1 -: SW]);
  assign out_o.cause   = ocause_q;
  assign out_o.last    = olast_q;

  // A stalled result is never overwritten by a new RAM read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !ram_re)
    else $error("RAM read issued while output is stalled");

  // A burst always has at least one packet left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BURST) |-> (cur_q < end_q))
    else $error("burst pointer past its end");

  // Window bookkeeping: base <= last_sent + 1 <= next_seq
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (base_q <= (last_sent_q + CNT_W'(1))) && (last_sent_q < next_seq_q))
    else $error("window pointers out of order");

  // A running timer always has ticks left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    timer_on_q |-> (timer_left_q != '0))
    else $error("timer running with zero ticks left");

endmodule

// ===== tb/gbn_tb_pkg.sv =====
`timescale 1ns / 1ps

package gbn_tb_pkg;
  import gbn_pkg::*;

  // op 3 is not decoded by the sender
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int unsigned SLOTS      = MSG_SLOTS_DEF;
  localparam int unsigned WIN_CAP    = WINDOW_MAX_DEF;
  localparam int unsigned REPORT_MAX = 10;

  // One command on the input channel
  typedef struct {
    logic [OP_W-1:0]          op;
    logic [LO_W-1:0]          lo;
    logic [MID_W-1:0]         mid;
    logic [HI_W-1:0]          hi;
    logic [PKT_W-1:0]         pkt_seq;
    logic [PKT_W-1:0]         pkt_ack;
    logic signed [PSUM_W-1:0] pkt_sum;
  } cmd_t;

  // One transmitted data packet
  typedef struct {
    logic [OSEQ_W-1:0]        seq;
    logic signed [OSUM_W-1:0] csum;
    logic [LO_W-1:0]          lo;
    logic [MID_W-1:0]         mid;
    logic [HI_W-1:0]          hi;
    logic [CAUSE_W-1:0]       cause;
    logic                     last;
  } pkt_t;

  // Sum of the 20 payload bytes, each one signed
  function automatic int payload_sum(logic [LO_W-1:0] lo, logic [MID_W-1:0] mid,
                                     logic [HI_W-1:0] hi);
    logic [8*PAYLOAD_BYTES-1:0] flat;
    int acc;
    flat = {hi, mid, lo};
    acc  = 0;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      acc += int'($signed(flat[8*k +: 8]));
    end
    return acc;
  endfunction

  // Window/timer predictor plus the queue of packets still to come out
  class gbn_scoreboard;
    logic [LO_W-1:0]    msg_lo  [SLOTS];
    logic [MID_W-1:0]   msg_mid [SLOTS];
    logic [HI_W-1:0]    msg_hi  [SLOTS];
    logic [15:0]        msg_sum [SLOTS];
    logic [15:0]        base;
    logic [15:0]        last_sent;
    logic [10:0]        next_seq;
    logic [15:0]        timer_left;
    bit                 timer_on;
    logic [WIN_W-1:0]   win_reg;
    logic [TMO_W-1:0]   tmo_reg;
    pkt_t               tx_expected[$];
    int unsigned        mismatches;

    function new();
      base       = 16'd1;
      last_sent  = 16'd0;
      next_seq   = 11'd1;
      timer_left = 16'd0;
      timer_on   = 1'b0;
      win_reg    = WINDOW_RST;
      tmo_reg    = TIMEOUT_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      if (idx == CFG_WINDOW_SIZE) begin
        win_reg = data[WIN_W-1:0];
      end else begin
        tmo_reg = data[TMO_W-1:0];
      end
    endfunction

    // Zero acts as one, oversize is clipped
    function int unsigned in_flight_limit();
      if (win_reg == 0) return 1;
      if (win_reg > WIN_CAP) return WIN_CAP;
      return win_reg;
    endfunction

    function void arm_timer();
      timer_left = (tmo_reg == 0) ? 16'd1 : tmo_reg;
      timer_on   = 1'b1;
    endfunction

    function void transmit(int unsigned seq, logic [CAUSE_W-1:0] cause);
      pkt_t p;
      p.seq   = OSEQ_W'(seq);
      p.csum  = msg_sum[seq][OSUM_W-1:0];
      p.lo    = msg_lo[seq];
      p.mid   = msg_mid[seq];
      p.hi    = msg_hi[seq];
      p.cause = cause;
      p.last  = 1'b0;
      tx_expected.push_back(p);
    endfunction

    // Update the predicted state for one accepted command
    function void note_command(cmd_t c);
      int unsigned n;
      int unsigned s;
      int calc;
      pkt_t tail;
      n = 0;
      case (c.op)
        OP_SEND: begin
          // store full: the message is dropped
          if (next_seq < SLOTS) begin
            s = next_seq;
            msg_lo[s]  = c.lo;
            msg_mid[s] = c.mid;
            msg_hi[s]  = c.hi;
            msg_sum[s] = 16'(int'(s) + payload_sum(c.lo, c.mid, c.hi));
            if (s < base + in_flight_limit()) begin
              transmit(s, CAUSE_FRESH);
              n++;
              last_sent = 16'(s);
              if (base == s) arm_timer();
            end
            next_seq = 11'(s + 1);
          end
        end
        OP_ACK: begin
          calc = int'(c.pkt_seq) + int'(c.pkt_ack) + payload_sum(c.lo, c.mid, c.hi);
          // corrupt, old or not-yet-sent acks are dropped
          if (calc == c.pkt_sum && c.pkt_ack >= base && c.pkt_ack <= last_sent) begin
            base = c.pkt_ack + 16'd1;
            for (int unsigned i = last_sent + 1;
                 i < next_seq && i < base + in_flight_limit(); i++) begin
              transmit(i, CAUSE_SLIDE);
              n++;
              last_sent = 16'(i);
            end
            if (base == next_seq) timer_on = 1'b0;
            else arm_timer();
          end
        end
        OP_TICK: begin
          if (timer_on) begin
            if (timer_left > 1) begin
              timer_left--;
            end else begin
              arm_timer();
              for (int unsigned i = base; i <= last_sent && n < WIN_CAP; i++) begin
                transmit(i, CAUSE_RETX);
                n++;
              end
            end
          end
        end
        default: ;
      endcase
      if (n > 0) begin
        tail      = tx_expected.pop_back();
        tail.last = 1'b1;
        tx_expected.push_back(tail);
      end
    endfunction

    // Compare one transmitted packet with the oldest expected one
    function void check_packet(pkt_t got);
      pkt_t want;
      if (tx_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("tb: unexpected packet seq %0d cause %0d", got.seq, got.cause);
        end
        return;
      end
      want = tx_expected.pop_front();
      if (got.seq !== want.seq || got.csum !== want.csum || got.lo !== want.lo ||
          got.mid !== want.mid || got.hi !== want.hi || got.cause !== want.cause ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("tb: mismatch exp seq %0d sum %0d cause %0d last %0b lo %h mid %h hi %h",
                   want.seq, want.csum, want.cause, want.last, want.lo, want.mid, want.hi);
          $display("tb:          got seq %0d sum %0d cause %0d last %0b lo %h mid %h hi %h",
                   got.seq, got.csum, got.cause, got.last, got.lo, got.mid, got.hi);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gbn_pkg::*;
  import gbn_tb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;

  gbn_in_if  cmd_if ();
  gbn_out_if pkt_if ();
  gbn_cfg_if cfg_if ();

  go_back_n_sender dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (pkt_if),
    .cfg_i  (cfg_if)
  );

  gbn_scoreboard sb = new();

  bit          calm      = 1'b0;
  int unsigned hold_asks = 0;
  int unsigned cycles    = 0;
  pkt_t        seen_pkt;

  // Settings per random phase
  logic [WIN_W-1:0] phase_win [6] = '{7'd4, 7'd64, 7'd1, 7'd2, 7'd100, 7'd16};
  logic [TMO_W-1:0] phase_tmo [6] = '{16'd3, 16'd1, 16'd2, 16'd5, 16'hffff, 16'd4};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Packet monitor
  always @(posedge clk) begin
    if (rst_n && pkt_if.valid && pkt_if.ready) begin
      seen_pkt.seq   = pkt_if.out_seq;
      seen_pkt.csum  = pkt_if.out_sum;
      seen_pkt.lo    = pkt_if.out_lo;
      seen_pkt.mid   = pkt_if.out_mid;
      seen_pkt.hi    = pkt_if.out_hi;
      seen_pkt.cause = pkt_if.cause;
      seen_pkt.last  = pkt_if.last;
      sb.check_packet(seen_pkt);
    end
  end

  // Packet receiver: random stalls, plus a long hold-off when asked
  initial begin
    int unsigned hold_left;
    int unsigned holds_done;
    hold_left    = 0;
    holds_done   = 0;
    pkt_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        holds_done = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pkt_if.ready <= 1'b0;
      end else begin
        pkt_if.ready <= calm || ($urandom_range(0, 99) >= 11);
      end
    end
  end

  function automatic cmd_t noise_cmd(logic [OP_W-1:0] op);
    cmd_t c;
    c.op      = op;
    c.lo      = {$urandom, $urandom};
    c.mid     = {$urandom, $urandom};
    c.hi      = $urandom;
    c.pkt_seq = 16'($urandom);
    c.pkt_ack = 16'($urandom);
    c.pkt_sum = $urandom;
    return c;
  endfunction

  function automatic cmd_t send_cmd(logic [LO_W-1:0] lo, logic [MID_W-1:0] mid,
                                    logic [HI_W-1:0] hi);
    cmd_t c;
    c     = noise_cmd(OP_SEND);
    c.lo  = lo;
    c.mid = mid;
    c.hi  = hi;
    return c;
  endfunction

  // Ack with a matching checksum, or one bit of it flipped
  function automatic cmd_t ack_cmd(logic [PKT_W-1:0] pseq, logic [PKT_W-1:0] pack,
                                   bit corrupt);
    cmd_t c;
    c         = noise_cmd(OP_ACK);
    c.pkt_seq = pseq;
    c.pkt_ack = pack;
    c.pkt_sum = int'(pseq) + int'(pack) + payload_sum(c.lo, c.mid, c.hi);
    if (corrupt) c.pkt_sum ^= 32'd1 << $urandom_range(0, 31);
    return c;
  endfunction

  // Mostly acks inside the outstanding range, some broken ones
  function automatic cmd_t pick_ack();
    int unsigned kind;
    kind = $urandom_range(0, 9);
    if (kind < 7 && sb.last_sent >= sb.base) begin
      return ack_cmd(16'($urandom), 16'($urandom_range(sb.base, sb.last_sent)), 1'b0);
    end
    if (kind == 7) begin
      return ack_cmd(16'($urandom), 16'($urandom_range(sb.base, sb.last_sent + 1)), 1'b1);
    end
    if (kind == 8 && sb.base > 1) begin
      return ack_cmd(16'($urandom), 16'($urandom_range(0, sb.base - 1)), 1'b0);
    end
    return ack_cmd(16'($urandom), 16'($urandom_range(sb.last_sent + 1, 65535)), 1'b0);
  endfunction

  // Drive one command and wait for its transaction
  task automatic push_cmd(cmd_t c);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 11) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid       <= 1'b1;
    cmd_if.op          <= c.op;
    cmd_if.payload_lo  <= c.lo;
    cmd_if.payload_mid <= c.mid;
    cmd_if.payload_hi  <= c.hi;
    cmd_if.pkt_seq     <= c.pkt_seq;
    cmd_if.pkt_ack     <= c.pkt_ack;
    cmd_if.pkt_sum     <= c.pkt_sum;
    do @(posedge clk); while (!cmd_if.ready);
    sb.note_command(c);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Stop sending, wait for every expected packet, then let the pipe empty
  task automatic quiesce();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (sb.tx_expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_random(int unsigned count, int unsigned send_pct);
    int unsigned r;
    cmd_t c;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < send_pct) c = noise_cmd(OP_SEND);
      else if (r < send_pct + 28) c = pick_ack();
      else if (r < 97) c = noise_cmd(OP_TICK);
      else c = noise_cmd(OP_UNUSED);
      push_cmd(c);
    end
  endtask

  initial begin
    cmd_if.valid       = 1'b0;
    cmd_if.op          = OP_SEND;
    cmd_if.payload_lo  = '0;
    cmd_if.payload_mid = '0;
    cmd_if.payload_hi  = '0;
    cmd_if.pkt_seq     = '0;
    cmd_if.pkt_ack     = '0;
    cmd_if.pkt_sum     = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_WINDOW_SIZE;
    cfg_if.data        = '0;
    rst_n              = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: payload extremes under the reset settings
    push_cmd(send_cmd('0, '0, '0));
    push_cmd(send_cmd('1, '1, '1));
    push_cmd(send_cmd({8{8'h80}}, {8{8'h80}}, {4{8'h80}}));
    push_cmd(send_cmd({8{8'h7f}}, {8{8'h7f}}, {4{8'h7f}}));
    push_cmd(noise_cmd(OP_TICK));
    push_cmd(ack_cmd(16'($urandom), 16'd1, 1'b1));   // bad checksum
    push_cmd(ack_cmd(16'hffff, 16'hffff, 1'b0));     // acks a packet never sent
    push_cmd(ack_cmd(16'd0, 16'd1, 1'b0));           // base moves to 2
    push_cmd(ack_cmd(16'($urandom), 16'd1, 1'b0));   // now behind the base
    push_cmd(noise_cmd(OP_UNUSED));

    // Window of zero acts as one, zero timeout as one tick
    quiesce();
    write_reg(CFG_WINDOW_SIZE, 16'd0);
    write_reg(CFG_TIMEOUT_TICKS, 16'd0);
    push_cmd(noise_cmd(OP_SEND));                    // queued outside the window
    push_cmd(noise_cmd(OP_SEND));
    push_cmd(ack_cmd(16'($urandom), 16'd4, 1'b0));   // slide releases one
    push_cmd(noise_cmd(OP_TICK));                    // expires at once
    push_cmd(ack_cmd(16'($urandom), 16'd5, 1'b0));
    push_cmd(noise_cmd(OP_TICK));
    push_cmd(ack_cmd(16'($urandom), 16'd6, 1'b0));   // all acked, timer stops
    push_cmd(noise_cmd(OP_TICK));                    // ignored while stopped

    // Oversize window clips to the maximum
    quiesce();
    write_reg(CFG_WINDOW_SIZE, 16'd127);
    write_reg(CFG_TIMEOUT_TICKS, 16'd1);
    push_cmd(noise_cmd(OP_SEND));
    push_cmd(noise_cmd(OP_SEND));
    push_cmd(noise_cmd(OP_SEND));
    push_cmd(noise_cmd(OP_TICK));

    // Random phases, one setting each
    for (int ph = 0; ph < 6; ph++) begin
      quiesce();
      write_reg(CFG_WINDOW_SIZE, {9'($urandom), phase_win[ph]});
      write_reg(CFG_TIMEOUT_TICKS, phase_tmo[ph]);
      case (ph)
        1: begin
          hold_asks++;
          run_random(50, 70);
        end
        2: begin
          calm = 1'b1;
          run_random(50, 45);
          calm = 1'b0;
        end
        3: begin
          run_random(25, 45);
          quiesce();
          run_random(25, 45);
        end
        default: run_random(50, 45);
      endcase
    end

    quiesce();
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.tx_expected.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
